// ----- rtl/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Field widths, request modes, status codes and chunk kinds shared by the
// allocator's ports and logic.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 7;
    localparam int ADDR_W   = 9;
    localparam int STATUS_W = 2;
    localparam int KIND_W   = 2;

    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [KIND_W-1:0]   t_kind;

    // request modes
    localparam t_mode MODE_ALLOC_ONE   = 2'd0;
    localparam t_mode MODE_ALLOC_ARRAY = 2'd1;
    localparam t_mode MODE_FREE        = 2'd2;
    localparam t_mode MODE_UNDEF       = 2'd3;

    // result status
    localparam t_status STATUS_OK      = 2'd0;
    localparam t_status STATUS_NOSPACE = 2'd1;
    localparam t_status STATUS_TOOBIG  = 2'd2;

    // chunk kinds
    localparam t_kind KIND_UNUSED = 2'd0;
    localparam t_kind KIND_SINGLE = 2'd1;
    localparam t_kind KIND_ARRAY  = 2'd2;

endpackage

// ----- rtl/bitmap_block_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit allocator over a pool of chunks, each with a free bitmap, kept in
// a chunk table with one write port and one read port, and walked by a small sequencer.
// ----------------------------------------------------------------------------
// One request is taken at a time. Each chunk record is read from the table
// in ST_READ and then evaluated in ST_EVAL, so an allocation walks the chunks
// in turn, at most NUM_CHUNKS of them; a single-block allocation then
// searches the chosen bitmap in ST_FIND one byte a cycle, through at most
// ceil(BLOCKS_PER_CHUNK/8) bytes. A changed record is written back in
// ST_WRITE, the result is loaded in ST_DONE once the output register is
// free, and the block is ready again the cycle after. A free walks the
// chunks until it reaches the addressed one. After reset the chunk table is
// swept clear, one chunk a cycle, and no request is taken until the sweep
// ends. A finished result waits in the output register; a new request can
// be taken meanwhile.
module bitmap_block_allocator_unit #(
    parameter int BLOCKS_PER_CHUNK = 64,
    parameter int NUM_CHUNKS       = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  bba_pkg::t_mode   i_mode,
    input  bba_pkg::t_count  i_block_count,
    input  bba_pkg::t_addr   i_free_address,
    output logic             o_valid,
    input  logic             i_ready,
    output bba_pkg::t_addr   o_block_address,
    output bba_pkg::t_status o_status
);
    import bba_pkg::*;

    localparam int IDX_W  = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int OFF_W  = $clog2(BLOCKS_PER_CHUNK);
    localparam int BASE_W = $clog2(NUM_CHUNKS * BLOCKS_PER_CHUNK + 1);
    localparam int CMP_W  = (BASE_W > ADDR_W) ? BASE_W + 1 : ADDR_W + 1;
    localparam int GRP    = (BLOCKS_PER_CHUNK + 7) / 8;
    localparam int GRP_W  = (GRP > 1) ? $clog2(GRP) : 1;
    localparam int PAD_W  = GRP * 8;

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_FIND  = 3'd4;
    localparam logic [2:0] ST_WRITE = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    typedef struct packed {
        t_kind                       kind;
        t_count                      alen;
        logic [BLOCKS_PER_CHUNK-1:0] bmap;
    } t_chunk;

    localparam t_chunk CHUNK_UNUSED = '{kind: KIND_UNUSED, alen: '0, bmap: '1};
    localparam t_chunk CHUNK_FRESH  = '{kind: KIND_SINGLE, alen: '0, bmap: '1};

    // chunk table
    t_chunk mem [NUM_CHUNKS];
    t_chunk r_rdata;

    logic [2:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [BASE_W-1:0] r_base, n_base;
    t_mode             r_mode, n_mode;
    t_count            r_count, n_count;
    t_addr             r_faddr, n_faddr;
    logic              r_un_vld, n_un_vld;
    logic [IDX_W-1:0]  r_un_idx, n_un_idx;
    logic [BASE_W-1:0] r_un_base, n_un_base;
    logic [IDX_W-1:0]  r_sel_idx, n_sel_idx;
    logic [BASE_W-1:0] r_sel_base, n_sel_base;
    t_chunk            r_word, n_word;
    logic [GRP_W-1:0]  r_grp, n_grp;
    t_addr             r_res_addr, n_res_addr;
    t_status           r_res_status, n_res_status;
    logic              r_out_vld, n_out_vld;
    t_addr             r_out_addr, n_out_addr;
    t_status           r_out_status, n_out_status;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    t_chunk            mem_wdata;

    logic              last_idx;
    logic              in_chunk;
    logic [OFF_W-1:0]  free_off;
    logic [OFF_W-1:0]  find_off;
    logic [CMP_W-1:0]  limit;
    logic [PAD_W-1:0]  pad_bmap;
    logic [7:0]        grp_bits;
    logic [2:0]        grp_pos;
    logic [BLOCKS_PER_CHUNK-1:0] arr_bmap;
    logic              too_big;

    assign o_ready         = (r_state == ST_IDLE);
    assign o_valid         = r_out_vld;
    assign o_block_address = r_out_addr;
    assign o_status        = r_out_status;

    // walk position and addressed chunk
    assign last_idx = (r_idx == IDX_W'(NUM_CHUNKS - 1));
    assign limit    = CMP_W'(r_base) + CMP_W'(BLOCKS_PER_CHUNK);
    assign in_chunk = (CMP_W'(r_faddr) < limit);
    assign free_off = OFF_W'(CMP_W'(r_faddr) - CMP_W'(r_base));
    assign too_big  = ({1'b0, i_block_count} > 8'(BLOCKS_PER_CHUNK));

    // byte-wise first-set-bit search
    assign pad_bmap = PAD_W'(r_word.bmap);
    assign grp_bits = 8'(pad_bmap >> {r_grp, 3'b000});

    always_comb begin
        grp_pos = '0;
        for (int b = 7; b >= 0; b--) begin
            if (grp_bits[b]) begin
                grp_pos = 3'(b);
            end
        end
    end

    assign find_off = OFF_W'({r_grp, grp_pos});

    // array bitmap: first r_count blocks used
    always_comb begin
        for (int b = 0; b < BLOCKS_PER_CHUNK; b++) begin
            arr_bmap[b] = (7'(b) >= r_count);
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_base       = r_base;
        n_mode       = r_mode;
        n_count      = r_count;
        n_faddr      = r_faddr;
        n_un_vld     = r_un_vld;
        n_un_idx     = r_un_idx;
        n_un_base    = r_un_base;
        n_sel_idx    = r_sel_idx;
        n_sel_base   = r_sel_base;
        n_word       = r_word;
        n_grp        = r_grp;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_out_vld    = r_out_vld;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_waddr    = r_sel_idx;
        mem_wdata    = r_word;

        // drop a taken result
        if (r_out_vld && i_ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = CHUNK_UNUSED;
                if (last_idx) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            ST_IDLE: begin
                if (i_valid) begin
                    n_mode       = i_mode;
                    n_count      = (i_block_count == '0) ? COUNT_W'(1) : i_block_count;
                    n_faddr      = i_free_address;
                    n_idx        = '0;
                    n_base       = '0;
                    n_un_vld     = 1'b0;
                    n_grp        = '0;
                    n_res_addr   = '0;
                    n_res_status = STATUS_NOSPACE;
                    if (i_mode == MODE_UNDEF) begin
                        n_state = ST_DONE;
                    end else if (i_mode == MODE_ALLOC_ARRAY && too_big) begin
                        n_res_status = STATUS_TOOBIG;
                        n_state      = ST_DONE;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end

            ST_READ: begin
                n_state = ST_EVAL;
            end

            ST_EVAL: begin
                n_sel_idx  = r_idx;
                n_sel_base = r_base;
                case (r_mode)
                    MODE_ALLOC_ONE: begin
                        if (r_rdata.kind == KIND_SINGLE && |r_rdata.bmap) begin
                            n_word  = r_rdata;
                            n_state = ST_FIND;
                        end else begin
                            // remember the lowest unused chunk as fallback
                            if (r_rdata.kind == KIND_UNUSED && !r_un_vld) begin
                                n_un_vld  = 1'b1;
                                n_un_idx  = r_idx;
                                n_un_base = r_base;
                            end
                            if (last_idx) begin
                                if (n_un_vld) begin
                                    n_sel_idx  = n_un_idx;
                                    n_sel_base = n_un_base;
                                    n_word     = CHUNK_FRESH;
                                    n_state    = ST_FIND;
                                end else begin
                                    n_state = ST_DONE;
                                end
                            end else begin
                                n_idx   = r_idx + 1'b1;
                                n_base  = r_base + BASE_W'(BLOCKS_PER_CHUNK);
                                n_state = ST_READ;
                            end
                        end
                    end

                    MODE_ALLOC_ARRAY: begin
                        if (r_rdata.kind == KIND_UNUSED) begin
                            n_word.kind  = KIND_ARRAY;
                            n_word.alen  = r_count;
                            n_word.bmap  = arr_bmap;
                            n_res_addr   = ADDR_W'(r_base);
                            n_res_status = STATUS_OK;
                            n_state      = ST_WRITE;
                        end else if (last_idx) begin
                            n_state = ST_DONE;
                        end else begin
                            n_idx   = r_idx + 1'b1;
                            n_base  = r_base + BASE_W'(BLOCKS_PER_CHUNK);
                            n_state = ST_READ;
                        end
                    end

                    MODE_FREE: begin
                        if (in_chunk) begin
                            n_state = ST_DONE;
                            if (r_rdata.kind == KIND_UNUSED) begin
                                n_state = ST_DONE;
                            end else if (r_rdata.kind == KIND_ARRAY && free_off == '0
                                         && r_rdata.alen != '0) begin
                                // release the whole run
                                n_word       = CHUNK_UNUSED;
                                n_res_addr   = r_faddr;
                                n_res_status = STATUS_OK;
                                n_state      = ST_WRITE;
                            end else if (!r_rdata.bmap[free_off]) begin
                                n_word                = r_rdata;
                                n_word.bmap[free_off] = 1'b1;
                                n_res_addr            = r_faddr;
                                n_res_status          = STATUS_OK;
                                n_state               = ST_WRITE;
                            end
                        end else if (last_idx) begin
                            n_state = ST_DONE;
                        end else begin
                            n_idx   = r_idx + 1'b1;
                            n_base  = r_base + BASE_W'(BLOCKS_PER_CHUNK);
                            n_state = ST_READ;
                        end
                    end

                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end

            ST_FIND: begin
                if (grp_bits != '0) begin
                    n_word.bmap[find_off] = 1'b0;
                    n_res_addr   = ADDR_W'(CMP_W'(r_sel_base) + CMP_W'(find_off));
                    n_res_status = STATUS_OK;
                    n_state      = ST_WRITE;
                end else if (r_grp == GRP_W'(GRP - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_grp = r_grp + 1'b1;
                end
            end

            ST_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = r_sel_idx;
                mem_wdata = r_word;
                n_state   = ST_DONE;
            end

            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_vld || i_ready) begin
                    n_out_vld    = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_res_status;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // chunk table port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[r_idx];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_base       <= n_base;
        r_mode       <= n_mode;
        r_count      <= n_count;
        r_faddr      <= n_faddr;
        r_un_vld     <= n_un_vld;
        r_un_idx     <= n_un_idx;
        r_un_base    <= n_un_base;
        r_sel_idx    <= n_sel_idx;
        r_sel_base   <= n_sel_base;
        r_word       <= n_word;
        r_grp        <= n_grp;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

endmodule
